>>> rtl/csc_pkg.sv
// Shared constants, types and tables of the coordinate converter.
package csc_pkg;

	// Word format
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Angle arithmetic: radians in Q30
	localparam int ANG_FRAC  = 30;
	localparam int STAGES    = 30;
	localparam int GUARD     = 24;
	localparam int ANG_W     = 34;
	localparam int VEC_W     = 60;
	localparam int ROT_W     = 34;
	localparam int RED_W     = 47;
	localparam int MOD_STEPS = 13;

	// Unit latencies in cycles
	localparam int ISQ_LAT = 32;
	localparam int VEC_LAT = STAGES + 1;
	localparam int ROT_LAT = MOD_STEPS + STAGES + 3;

	localparam logic signed [ANG_W-1:0] PI_Q30       = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
	localparam logic [RED_W-1:0]        TWO_PI_Q30   = 47'd6746518852;
	localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [ROT_W-1:0] ONE_Q30      = 34'sd1073741824;
	localparam logic signed [31:0]      DEG2RAD_Q30  = 32'sd18740330;
	localparam logic signed [31:0]      RAD_SCALE_IN = 32'sd1073741824;
	localparam logic signed [30:0]      RAD2DEG_Q24  = 31'sd961263669;
	localparam logic signed [30:0]      RAD_SCALE_OUT = 31'sd16777216;

	// atan(2^-i) in Q30
	localparam logic [29:0] ATAN_TAB [STAGES] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
	};

	typedef enum logic [1:0] {
		KIND_CART_SPH,
		KIND_SPH_CART,
		KIND_CART_CYL,
		KIND_CYL_CART
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SAT,
		ST_RZERO
	} status_t;

	typedef struct packed {
		kind_t                        kind;
		logic                         deg;
		logic signed [WORD_BITS-1:0]  a;
		logic signed [WORD_BITS-1:0]  b;
		logic signed [WORD_BITS-1:0]  c;
	} item_t;

endpackage

>>> rtl/csc_vec_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians.
module csc_vec_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [32:0]                  in_y,
	input  logic signed [32:0]                  in_x,
	output logic signed [csc_pkg::ANG_W-1:0]    out_z
);

	localparam int N = csc_pkg::STAGES;
	localparam int VW = csc_pkg::VEC_W;
	localparam int AW = csc_pkg::ANG_W;

	logic signed [VW-1:0] x_s [0:N];
	logic signed [VW-1:0] y_s [0:N];
	logic signed [AW-1:0] z_s [0:N];
	logic                 zf_s [0:N];

	logic signed [33:0] xw, yw;
	logic signed [AW-1:0] z0;

	// Fold left half-plane by +-pi
	always_comb begin
		xw = 34'(in_x);
		yw = 34'(in_y);
		z0 = '0;
		if (in_x < 0) begin
			xw = -xw;
			yw = -yw;
			z0 = (in_y >= 0) ? csc_pkg::PI_Q30 : -csc_pkg::PI_Q30;
		end
	end

	// Prep stage: scale up for guard bits
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= {{(VW-34-csc_pkg::GUARD){xw[33]}}, xw, {csc_pkg::GUARD{1'b0}}};
			y_s[0]  <= {{(VW-34-csc_pkg::GUARD){yw[33]}}, yw, {csc_pkg::GUARD{1'b0}}};
			z_s[0]  <= z0;
			zf_s[0] <= (in_x == '0) && (in_y == '0);
		end
	end

	// Micro-rotations, one per stage
	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [AW-1:0] ATN = AW'(csc_pkg::ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][VW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATN;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATN;
				end
				zf_s[i+1] <= zf_s[i];
			end
		end
	end

	// Origin has azimuth zero
	assign out_z = zf_s[N] ? '0 : z_s[N];

endmodule

>>> rtl/csc_rot_cordic.sv
// Pipelined angle reduction and rotation CORDIC: cos and sin in Q30.
module csc_rot_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [csc_pkg::RED_W-1:0]    in_ang,
	output logic signed [csc_pkg::ROT_W-1:0]    out_cos,
	output logic signed [csc_pkg::ROT_W-1:0]    out_sin
);

	localparam int N  = csc_pkg::STAGES;
	localparam int M  = csc_pkg::MOD_STEPS;
	localparam int RW = csc_pkg::RED_W;
	localparam int AW = csc_pkg::ANG_W;
	localparam int XW = csc_pkg::ROT_W;

	logic [RW-1:0]        m_s  [0:M];
	logic                 sg_s [0:M];
	logic signed [AW-1:0] a1_s;
	logic signed [AW-1:0] a_s  [0:N];
	logic signed [XW-1:0] x_s  [0:N];
	logic signed [XW-1:0] y_s  [0:N];
	logic                 ng_s [0:N];

	logic signed [AW:0] rem, red;

	// Magnitude and sign of the angle
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s[0] <= in_ang[RW-1];
			m_s[0]  <= in_ang[RW-1] ? RW'(-in_ang) : RW'(in_ang);
		end
	end

	// Remainder by 2*pi, one quotient bit per stage
	for (genvar j = 0; j < M; j++) begin : g_mod
		localparam logic [RW-1:0] DIV = csc_pkg::TWO_PI_Q30 << (M - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j+1]  <= (m_s[j] >= DIV) ? m_s[j] - DIV : m_s[j];
				sg_s[j+1] <= sg_s[j];
			end
		end
	end

	// Restore sign and bring into (-pi, pi]
	always_comb begin
		rem = $signed({1'b0, m_s[M][AW-1:0]});
		if (sg_s[M])
			rem = -rem;
		red = rem;
		if (rem > (AW+1)'(csc_pkg::PI_Q30))
			red = rem - $signed({1'b0, csc_pkg::TWO_PI_Q30[AW-1:0]});
		else if (rem <= -(AW+1)'(csc_pkg::PI_Q30))
			red = rem + $signed({1'b0, csc_pkg::TWO_PI_Q30[AW-1:0]});
	end

	always_ff @(posedge clk) begin
		if (en)
			a1_s <= AW'(red);
	end

	// Fold into [-pi/2, pi/2]
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= csc_pkg::INV_GAIN_Q30;
			y_s[0] <= '0;
			if (a1_s > csc_pkg::HALF_PI_Q30) begin
				a_s[0]  <= a1_s - csc_pkg::PI_Q30;
				ng_s[0] <= 1'b1;
			end else if (a1_s < -csc_pkg::HALF_PI_Q30) begin
				a_s[0]  <= a1_s + csc_pkg::PI_Q30;
				ng_s[0] <= 1'b1;
			end else begin
				a_s[0]  <= a1_s;
				ng_s[0] <= 1'b0;
			end
		end
	end

	// Micro-rotations
	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [AW-1:0] ATN = AW'(csc_pkg::ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!a_s[i][AW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - ATN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + ATN;
				end
				ng_s[i+1] <= ng_s[i];
			end
		end
	end

	assign out_cos = ng_s[N] ? -x_s[N] : x_s[N];
	assign out_sin = ng_s[N] ? -y_s[N] : y_s[N];

endmodule

>>> rtl/coordinate_system_converter_unit.sv
// Top level of the cartesian / spherical / cylindrical coordinate converter.
// Converts one word per clock, fully pipelined, while the output is not
// stalled. The latency is set by the radius path: a 32-step digit-by-digit
// square root followed by a 31-stage vectoring CORDIC and the degree/radian
// scaling. The sin/cos path (13-step modulo 2*pi reduction and a 30-stage
// rotation CORDIC) runs beside it. A stall on the output freezes the whole
// pipeline; s_axis_tready drops only while a finished word waits and
// m_axis_tready is low. The angle unit bit takes effect for words accepted
// after it is written.
module coordinate_system_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: bit 0 selects degrees
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // coord_a[31:0], coord_b[63:32], coord_c[95:64]
	input  logic [1:0]  s_axis_tuser,   // kind[1:0]
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // result_a[31:0], result_b[63:32], result_c[95:64]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	localparam int S_SUM   = 3;
	localparam int S_ISQ   = S_SUM + csc_pkg::ISQ_LAT;
	localparam int S_VEC   = S_ISQ + csc_pkg::VEC_LAT;
	localparam int S_VPROD = S_VEC + 1;
	localparam int S_OUT   = S_VPROD + 1;
	localparam int S_RTRIG = S_VEC - 2;
	localparam int S_ANG   = S_RTRIG - csc_pkg::ROT_LAT;
	localparam int S_APROD = S_ANG - 1;
	localparam int AW      = csc_pkg::ANG_W;
	localparam int XW      = csc_pkg::ROT_W;

	function automatic logic [63:0] isq_n(input logic [63:0] n, input logic [63:0] r,
		input logic [63:0] bit_v);
		return (n >= r + bit_v) ? n - (r + bit_v) : n;
	endfunction

	function automatic logic [63:0] isq_r(input logic [63:0] n, input logic [63:0] r,
		input logic [63:0] bit_v);
		return (n >= r + bit_v) ? (r >> 1) + bit_v : r >> 1;
	endfunction

	function automatic logic [32:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return {1'b1, 32'h7FFF_FFFF};
		if (v < -40'sd2147483648)
			return {1'b1, 32'h8000_0000};
		return {1'b0, v[31:0]};
	endfunction

	logic                  adv;
	logic                  deg_q;
	logic                  vld_s [1:S_OUT];
	csc_pkg::item_t        itm_s [1:S_OUT-1];

	logic [31:0]           ma, mb, mc;
	logic [63:0]           sqa_s2, sqb_s2, sqc_s2;
	logic [63:0]           plane_s3, full_s3;
	logic [63:0]           pn_s [0:csc_pkg::ISQ_LAT-1];
	logic [63:0]           pr_s [0:csc_pkg::ISQ_LAT-1];
	logic [63:0]           fn_s [0:csc_pkg::ISQ_LAT-1];
	logic [63:0]           fr_s [0:csc_pkg::ISQ_LAT-1];
	logic [31:0]           rho_d [S_ISQ+1:S_VPROD];
	logic [31:0]           rad_d [S_ISQ+1:S_VPROD];

	logic signed [AW-1:0]  az_z, pol_z;
	logic signed [30:0]    vk;
	logic signed [64:0]    azp_s67, polp_s67;

	logic signed [31:0]    dk;
	logic signed [63:0]    angbp_s17, angcp_s17;
	logic signed [csc_pkg::RED_W-1:0] angb_s18, angc_s18;
	logic signed [XW-1:0]  cs, sn, cp, sp, mulsel;
	logic signed [65:0]    ptm_s65, pc_s65;
	logic signed [XW-1:0]  cs_s65, sn_s65, cs_s66, sn_s66;
	logic signed [XW-1:0]  t_s66, rcr_s66, rcr_s67;
	logic signed [67:0]    pa_s67, pb_s67;

	csc_pkg::item_t        fin;
	logic signed [64:0]    vaz, vpol;
	logic signed [67:0]    rra, rrb;
	logic signed [39:0]    va, vb, vc;
	logic [32:0]           sa, sb, sc;
	logic                  rz;
	csc_pkg::status_t      st;

	logic [31:0]           res_a_s68, res_b_s68, res_c_s68;
	csc_pkg::status_t      status_s68;

	// Global advance: the output register is free or being drained
	assign adv           = !vld_s[S_OUT] || m_axis_tready;
	assign s_axis_tready = adv;

	// Angle unit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			deg_q <= 1'b0;
		else if (cfg_we)
			deg_q <= cfg_wdata;
	end

	// Valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_OUT; k++)
				vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= S_OUT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	// Input word and its delay line
	always_ff @(posedge clk) begin
		if (adv) begin
			itm_s[1].kind <= csc_pkg::kind_t'(s_axis_tuser);
			itm_s[1].deg  <= deg_q;
			itm_s[1].a    <= s_axis_tdata[31:0];
			itm_s[1].b    <= s_axis_tdata[63:32];
			itm_s[1].c    <= s_axis_tdata[95:64];
			for (int k = 2; k <= S_OUT-1; k++)
				itm_s[k] <= itm_s[k-1];
		end
	end

	// Squares of the magnitudes
	assign ma = itm_s[1].a[31] ? 32'(-itm_s[1].a) : 32'(itm_s[1].a);
	assign mb = itm_s[1].b[31] ? 32'(-itm_s[1].b) : 32'(itm_s[1].b);
	assign mc = itm_s[1].c[31] ? 32'(-itm_s[1].c) : 32'(itm_s[1].c);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqa_s2   <= 64'(ma) * 64'(ma);
			sqb_s2   <= 64'(mb) * 64'(mb);
			sqc_s2   <= 64'(mc) * 64'(mc);
		end
	end

	// Plane and full sums of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			plane_s3 <= sqa_s2 + sqb_s2;
			full_s3  <= sqa_s2 + sqb_s2 + sqc_s2;
		end
	end

	// Integer square roots, one result bit per stage
	for (genvar i = 0; i < csc_pkg::ISQ_LAT; i++) begin : g_isq
		localparam logic [63:0] BIT_V = 64'd1 << (2 * (csc_pkg::ISQ_LAT - 1 - i));
		logic [63:0] pn_in, pr_in, fn_in, fr_in;
		if (i == 0) begin : g_first
			assign pn_in = plane_s3;
			assign pr_in = '0;
			assign fn_in = full_s3;
			assign fr_in = '0;
		end else begin : g_next
			assign pn_in = pn_s[i-1];
			assign pr_in = pr_s[i-1];
			assign fn_in = fn_s[i-1];
			assign fr_in = fr_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pn_s[i] <= isq_n(pn_in, pr_in, BIT_V);
				pr_s[i] <= isq_r(pn_in, pr_in, BIT_V);
				fn_s[i] <= isq_n(fn_in, fr_in, BIT_V);
				fr_s[i] <= isq_r(fn_in, fr_in, BIT_V);
			end
		end
	end

	// Radii wait for the angle path
	always_ff @(posedge clk) begin
		if (adv) begin
			rho_d[S_ISQ+1] <= pr_s[csc_pkg::ISQ_LAT-1][31:0];
			rad_d[S_ISQ+1] <= fr_s[csc_pkg::ISQ_LAT-1][31:0];
			for (int k = S_ISQ+2; k <= S_VPROD; k++) begin
				rho_d[k] <= rho_d[k-1];
				rad_d[k] <= rad_d[k-1];
			end
		end
	end

	// Azimuth atan2(y, x) and polar atan2(rho, z)
	csc_vec_cordic u_vec_az (
		.clk   (clk),
		.en    (adv),
		.in_y  ({itm_s[S_ISQ].b[31], itm_s[S_ISQ].b}),
		.in_x  ({itm_s[S_ISQ].a[31], itm_s[S_ISQ].a}),
		.out_z (az_z)
	);

	csc_vec_cordic u_vec_pol (
		.clk   (clk),
		.en    (adv),
		.in_y  ({1'b0, pr_s[csc_pkg::ISQ_LAT-1][31:0]}),
		.in_x  ({itm_s[S_ISQ].c[31], itm_s[S_ISQ].c}),
		.out_z (pol_z)
	);

	// Output angle scaling (rounding shift done in the last stage)
	assign vk = itm_s[S_VEC].deg ? csc_pkg::RAD2DEG_Q24 : csc_pkg::RAD_SCALE_OUT;

	always_ff @(posedge clk) begin
		if (adv) begin
			azp_s67  <= 65'(az_z) * 65'(vk);
			polp_s67 <= 65'(pol_z) * 65'(vk);
		end
	end

	// Input angles to Q30 radians
	assign dk = itm_s[S_APROD-1].deg ? csc_pkg::DEG2RAD_Q30 : csc_pkg::RAD_SCALE_IN;

	always_ff @(posedge clk) begin
		if (adv) begin
			angbp_s17 <= 64'(itm_s[S_APROD-1].b) * 64'(dk);
			angcp_s17 <= 64'(itm_s[S_APROD-1].c) * 64'(dk);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angb_s18 <= csc_pkg::RED_W'((angbp_s17 + 64'sd32768) >>> csc_pkg::FRAC_BITS);
			angc_s18 <= csc_pkg::RED_W'((angcp_s17 + 64'sd32768) >>> csc_pkg::FRAC_BITS);
		end
	end

	// cos/sin of azimuth and polar angle
	csc_rot_cordic u_rot_az (
		.clk     (clk),
		.en      (adv),
		.in_ang  (angb_s18),
		.out_cos (cs),
		.out_sin (sn)
	);

	csc_rot_cordic u_rot_pol (
		.clk     (clk),
		.en      (adv),
		.in_ang  (angc_s18),
		.out_cos (cp),
		.out_sin (sp)
	);

	// t = r*sin(polar) for spherical, t = r for cylindrical
	assign mulsel = (itm_s[S_RTRIG].kind == csc_pkg::KIND_SPH_CART) ? sp : csc_pkg::ONE_Q30;

	always_ff @(posedge clk) begin
		if (adv) begin
			ptm_s65 <= 66'(itm_s[S_RTRIG].a) * 66'(mulsel);
			pc_s65  <= 66'(itm_s[S_RTRIG].a) * 66'(cp);
			cs_s65  <= cs;
			sn_s65  <= sn;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s66   <= XW'((ptm_s65 + (66'sd1 <<< (csc_pkg::ANG_FRAC - 1))) >>> csc_pkg::ANG_FRAC);
			rcr_s66 <= XW'((pc_s65 + (66'sd1 <<< (csc_pkg::ANG_FRAC - 1))) >>> csc_pkg::ANG_FRAC);
			cs_s66  <= cs_s65;
			sn_s66  <= sn_s65;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s67  <= 68'(t_s66) * 68'(cs_s66);
			pb_s67  <= 68'(t_s66) * 68'(sn_s66);
			rcr_s67 <= rcr_s66;
		end
	end

	// Rounding, selection by kind, saturation
	assign fin  = itm_s[S_OUT-1];
	assign vaz  = (azp_s67 + (65'sd1 <<< 37)) >>> 38;
	assign vpol = (polp_s67 + (65'sd1 <<< 37)) >>> 38;
	assign rra  = (pa_s67 + (68'sd1 <<< (csc_pkg::ANG_FRAC - 1))) >>> csc_pkg::ANG_FRAC;
	assign rrb  = (pb_s67 + (68'sd1 <<< (csc_pkg::ANG_FRAC - 1))) >>> csc_pkg::ANG_FRAC;

	always_comb begin
		rz = 1'b0;
		va = '0;
		vb = '0;
		vc = '0;
		unique case (fin.kind)
			csc_pkg::KIND_CART_SPH: begin
				if (rad_d[S_VPROD] == '0) begin
					rz = 1'b1;
				end else begin
					va = $signed({8'd0, rad_d[S_VPROD]});
					vb = 40'(vaz);
					vc = 40'(vpol);
				end
			end
			csc_pkg::KIND_CART_CYL: begin
				va = $signed({8'd0, rho_d[S_VPROD]});
				vb = 40'(vaz);
				vc = 40'(fin.c);
			end
			csc_pkg::KIND_SPH_CART: begin
				va = 40'(rra);
				vb = 40'(rrb);
				vc = 40'(rcr_s67);
			end
			csc_pkg::KIND_CYL_CART: begin
				va = 40'(rra);
				vb = 40'(rrb);
				vc = 40'(fin.c);
			end
		endcase
	end

	assign sa = sat32(va);
	assign sb = sat32(vb);
	assign sc = sat32(vc);

	always_comb begin
		if (rz)
			st = csc_pkg::ST_RZERO;
		else if (sa[32] || sb[32] || sc[32])
			st = csc_pkg::ST_SAT;
		else
			st = csc_pkg::ST_OK;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_a_s68  <= sa[31:0];
			res_b_s68  <= sb[31:0];
			res_c_s68  <= sc[31:0];
			status_s68 <= st;
		end
	end

	assign m_axis_tvalid = vld_s[S_OUT];
	assign m_axis_tdata  = {res_c_s68, res_b_s68, res_a_s68};
	assign m_axis_tuser  = status_s68;

endmodule

>>> rtl/csc_checker.sv
// Port-level assertions for the coordinate converter, bound to the top level.
module csc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// Input is taken whenever the output slot is free or draining
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled with free output");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output stalled");

	// Zero radius gives all-zero results; no result word carries an unused status code
	a_rzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == csc_pkg::ST_RZERO |-> m_axis_tdata == '0)
		else $error("zero radius with nonzero results");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined status code");

endmodule

bind coordinate_system_converter_unit csc_checker u_csc_checker (.*);

>>> tb/coordinate_system_converter_unit_checker.sv
// Checker of the coordinate converter: predicts every result word and compares.
module coordinate_system_converter_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] ra;
		logic signed [31:0] rb;
		logic signed [31:0] rc;
		csc_pkg::status_t   st;
	} conv_result_t;

	conv_result_t expected_words[$];
	logic         deg_sel;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= r + bit_v) begin
				n = n - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r;
	endfunction

	function automatic longint round_shift(longint v, int s);
		if (s <= 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring CORDIC, Q30 radians
	function automatic longint vec_angle(longint y, longint x);
		longint z, nx, ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(csc_pkg::PI_Q30) : -longint'(csc_pkg::PI_Q30);
			x = -x;
			y = -y;
		end
		x = x <<< csc_pkg::GUARD;
		y = y <<< csc_pkg::GUARD;
		for (int i = 0; i < csc_pkg::STAGES; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i);
				z = z + longint'(csc_pkg::ATAN_TAB[i]);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i);
				z = z - longint'(csc_pkg::ATAN_TAB[i]);
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	// rotation CORDIC with reduction to [-pi/2, pi/2]
	function automatic void rot_sincos(input longint ang, output longint c, output longint s);
		longint x, y, nx, ny, pi_v, two_pi;
		bit flip;
		pi_v = longint'(csc_pkg::PI_Q30);
		two_pi = longint'(csc_pkg::TWO_PI_Q30);
		x = longint'(csc_pkg::INV_GAIN_Q30);
		y = 0;
		flip = 0;
		ang = ang % two_pi;
		if (ang > pi_v) ang = ang - two_pi;
		if (ang <= -pi_v) ang = ang + two_pi;
		if (ang > longint'(csc_pkg::HALF_PI_Q30)) begin
			ang = ang - pi_v; flip = 1;
		end else if (ang < -longint'(csc_pkg::HALF_PI_Q30)) begin
			ang = ang + pi_v; flip = 1;
		end
		for (int i = 0; i < csc_pkg::STAGES; i++) begin
			if (ang >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i);
				ang = ang - longint'(csc_pkg::ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i);
				ang = ang + longint'(csc_pkg::ATAN_TAB[i]);
			end
			x = nx;
			y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint to_radians(longint v, logic deg);
		if (deg)
			return round_shift(v * longint'(csc_pkg::DEG2RAD_Q30), csc_pkg::FRAC_BITS);
		return v <<< (csc_pkg::ANG_FRAC - csc_pkg::FRAC_BITS);
	endfunction

	function automatic longint from_radians(longint a, logic deg);
		if (deg)
			return round_shift(a * longint'(csc_pkg::RAD2DEG_Q24),
				csc_pkg::ANG_FRAC + 24 - csc_pkg::FRAC_BITS);
		return round_shift(a, csc_pkg::ANG_FRAC - csc_pkg::FRAC_BITS);
	endfunction

	function automatic longint clamp32(longint v, inout bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1; return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1; return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic conv_result_t predict_conversion(csc_pkg::kind_t k, longint a,
			longint b, longint c, logic deg);
		conv_result_t res;
		longint ra, rb, rc, cs, sn, cp, sp, t;
		longint unsigned plane, r;
		bit rzero, hit;
		ra = 0; rb = 0; rc = 0;
		rzero = 0;
		hit = 0;
		plane = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b);
		case (k)
			csc_pkg::KIND_CART_SPH: begin
				r = int_sqrt(plane + magnitude(c) * magnitude(c));
				if (r == 0) begin
					rzero = 1;
				end else begin
					ra = longint'(r);
					rb = from_radians(vec_angle(b, a), deg);
					rc = from_radians(vec_angle(longint'(int_sqrt(plane)), c), deg);
				end
			end
			csc_pkg::KIND_SPH_CART: begin
				rot_sincos(to_radians(b, deg), cs, sn);
				rot_sincos(to_radians(c, deg), cp, sp);
				t = round_shift(a * sp, csc_pkg::ANG_FRAC);
				ra = round_shift(t * cs, csc_pkg::ANG_FRAC);
				rb = round_shift(t * sn, csc_pkg::ANG_FRAC);
				rc = round_shift(a * cp, csc_pkg::ANG_FRAC);
			end
			csc_pkg::KIND_CART_CYL: begin
				ra = longint'(int_sqrt(plane));
				rb = from_radians(vec_angle(b, a), deg);
				rc = c;
			end
			default: begin
				rot_sincos(to_radians(b, deg), cs, sn);
				ra = round_shift(a * cs, csc_pkg::ANG_FRAC);
				rb = round_shift(a * sn, csc_pkg::ANG_FRAC);
				rc = c;
			end
		endcase
		res.ra = 32'(clamp32(ra, hit));
		res.rb = 32'(clamp32(rb, hit));
		res.rc = 32'(clamp32(rc, hit));
		res.st = rzero ? csc_pkg::ST_RZERO : (hit ? csc_pkg::ST_SAT : csc_pkg::ST_OK);
		return res;
	endfunction

	assign pending = expected_words.size();

	// watch both channels and the angle unit register
	always @(posedge clk or negedge arst_n) begin
		conv_result_t exp_w, got_w;
		if (!arst_n) begin
			deg_sel <= 1'b0;
			fail_count <= 0;
			checked <= 0;
			expected_words.delete();
		end else begin
			if (cfg_we)
				deg_sel <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(predict_conversion(
					csc_pkg::kind_t'(s_axis_tuser),
					longint'($signed(s_axis_tdata[31:0])),
					longint'($signed(s_axis_tdata[63:32])),
					longint'($signed(s_axis_tdata[95:64])), deg_sel));
			if (m_axis_tvalid && m_axis_tready) begin
				got_w = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
					csc_pkg::status_t'(m_axis_tuser)};
				checked <= checked + 1;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, got_w);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (exp_w != got_w) begin
						$display("%0t: mismatch expected a=%h b=%h c=%h st=%0d actual a=%h b=%h c=%h st=%0d",
							$time, exp_w.ra, exp_w.rb, exp_w.rc, exp_w.st,
							got_w.ra, got_w.rb, got_w.rc, got_w.st);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/coordinate_system_converter_unit_test.sv
// Top of the coordinate converter testbench: stimulus, stalls and verdict.
module coordinate_system_converter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 90;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	int          fail_count, pending, checked;
	int          burst_left = 0;
	int          words_sent = 0;
	int          cycle_count = 0;

	coordinate_system_converter_unit u_dut (.*);

	coordinate_system_converter_unit_checker u_chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: free-running stretches alternate with random stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ((cycle_count % 300) < 100)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 9) < 6);
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("coordinate_system_converter_unit_test NOT OK");
			$finish;
		end
	end

	// one input word, sent in bursts with random gaps
	task automatic send_word(csc_pkg::kind_t k, logic [31:0] a, logic [31:0] b,
		logic [31:0] c);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c, b, a};
		s_axis_tuser <= k;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	// register write once all results are out and the pipe has drained
	task automatic set_degrees(logic v);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
			2: return $urandom_range(0, 32'h0fff_ffff) - 32'h0800_0000;
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0001_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			4: return $urandom_range(0, 32'h00b4_0000) - 32'h005a_0000;
			default: return $urandom_range(0, 32'h0007_ffff) - 32'h0003_ffff;
		endcase
	endfunction

	task automatic directed_words();
		// origin and zero-plane cases
		send_word(csc_pkg::KIND_CART_SPH, 32'h0, 32'h0, 32'h0);
		send_word(csc_pkg::KIND_CART_SPH, 32'h0, 32'h0, 32'hfffe_0000);
		send_word(csc_pkg::KIND_CART_CYL, 32'h0, 32'h0, 32'h0005_0000);
		// full-scale and negative coordinates; the radius saturates in the first three
		send_word(csc_pkg::KIND_CART_SPH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_word(csc_pkg::KIND_CART_SPH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_word(csc_pkg::KIND_CART_CYL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_word(csc_pkg::KIND_CART_CYL, 32'hffff_0000, 32'h0, 32'h7fff_ffff);
		send_word(csc_pkg::KIND_CART_SPH, 32'hffff_0000, 32'hffff_ffff, 32'h0001_0000);
		// conversions back with extreme radius and angles
		send_word(csc_pkg::KIND_SPH_CART, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_word(csc_pkg::KIND_SPH_CART, 32'h8000_0000, 32'h0, 32'h0001_921f);
		send_word(csc_pkg::KIND_SPH_CART, 32'h0001_0000, 32'h0003_243f, 32'h0003_243f);
		send_word(csc_pkg::KIND_CYL_CART, 32'h8000_0000, 32'h0003_243f, 32'h8000_0000);
		send_word(csc_pkg::KIND_CYL_CART, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_word(csc_pkg::KIND_CYL_CART, 32'h0002_0000, 32'h005a_0000, 32'h0);
		send_word(csc_pkg::KIND_SPH_CART, 32'h0, 32'h0, 32'h0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			set_degrees(phase[0]);
			if (phase < 2)
				directed_words();
			for (int n = 0; n < 225; n++)
				send_word(csc_pkg::kind_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
					pick_coord());
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d words over radian and degree phases, %0d results compared.",
			words_sent, checked);
		$display("Covered all four conversion kinds, origin, full-scale and saturating cases.");
		if (fail_count == 0 && pending == 0)
			$display("coordinate_system_converter_unit_test OK");
		else
			$display("coordinate_system_converter_unit_test NOT OK");
		$finish;
	end

endmodule
